[rtl/core/array_list_insert_erase_defines.svh]
// Assertion macros shared by the array list checker
`ifndef ARRAY_LIST_INSERT_ERASE_DEFINES_SVH
`define ARRAY_LIST_INSERT_ERASE_DEFINES_SVH

// Base form: clocked on clk_i, quiet while reset is asserted
`define ALI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error("ali_checker: property failed");

// Same-cycle implication
`define ALI_ASSERT_IMP(name, ante, cons) \
  `ALI_ASSERT(name, (ante) |-> (cons))

// Next-cycle implication
`define ALI_ASSERT_NXT(name, ante, cons) \
  `ALI_ASSERT(name, (ante) |=> (cons))

`endif

[rtl/core/ali_pkg.sv]
// Types, constants and codes for the array list block
`default_nettype none

package ali_pkg;

  localparam int unsigned LIST_CAP = 64;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned IDX_W    = $clog2(LIST_CAP);
  localparam int unsigned CNT_W    = $clog2(LIST_CAP + 1);
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned GRP_NUM  = (LIST_CAP + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_INSERT = 2'd2,
    FN_ERASE  = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ERASE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } ali_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]  length;
    logic [STAT_W-1:0] status;
  } ali_out_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] value;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/array_list_insert_erase.sv]
// Array list top level: an ordered list of up to LIST_CAP 64-bit words with push, pop,
// insert at a position and erase at a position. The words sit in a chain of cells, one
// word per cell, and every operation moves the whole chain in the cycle the item is
// transferred, so insert and erase cost no more than push and pop. Each item gives one
// result: the removed word (zero unless a pop or erase succeeded), the new length and a
// status (ok, full, empty, position out of range); on any error the list is untouched.
// The result passes through the registered OR tree that brings the removed word out of
// the chain in groups of eight cells, and then through the output register. One item is
// in flight at a time; a new item is taken in the cycle its predecessor's result is
// transferred, so the block never takes an item before it is done with the last one.
// Nothing needs clearing after reset: the list starts empty.
`default_nettype none

module array_list_insert_erase import ali_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ali_in_t  in_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ali_out_t      out_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_OUT    = 3'b100
  } state_e;

  state_e            state_d, state_q;
  logic [CNT_W-1:0]  count_d, count_q;
  logic [LEN_W-1:0]  len_q;
  status_e           stat_d, stat_q;
  ali_out_t          out_q;
  cell_cmd_t         cmd;
  logic              in_acc;
  logic [CMP_W-1:0]  cnt_ext, pos_ext;
  logic [CNT_W-1:0]  cnt_dec;
  logic              full, empty;
  logic [DATA_W-1:0] removed;

  logic [LIST_CAP-1:0][DATA_W-1:0] entry;
  logic [LIST_CAP-1:0][DATA_W-1:0] rd_val;

  // Take a new item when idle or as the waiting result leaves
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(in_i.position);
  assign cnt_dec = count_q - CNT_W'(1);
  assign full    = (count_q == CNT_W'(LIST_CAP));
  assign empty   = (count_q == '0);

  // Decode the operation into a chain command, new count and status
  always_comb begin
    cmd       = '0;
    cmd.op    = CMD_HOLD;
    cmd.value = in_i.value;
    count_d   = count_q;
    stat_d    = ST_OK;
    if (in_acc) begin
      case (func_e'(in_i.func))
        FN_PUSH: begin
          if (full) begin
            stat_d = ST_FULL;
          end else begin
            cmd.op     = CMD_WRITE;
            cmd.wr_idx = count_q[IDX_W-1:0];
            count_d    = count_q + CNT_W'(1);
          end
        end
        FN_POP: begin
          if (empty) begin
            stat_d = ST_EMPTY;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = cnt_dec[IDX_W-1:0];
            count_d    = cnt_dec;
          end
        end
        FN_INSERT: begin
          if (full) begin
            stat_d = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            stat_d = ST_RANGE;
          end else begin
            cmd.op     = CMD_WRITE;
            cmd.wr_idx = pos_ext[IDX_W-1:0];
            count_d    = count_q + CNT_W'(1);
          end
        end
        FN_ERASE: begin
          if (empty) begin
            stat_d = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            stat_d = ST_RANGE;
          end else begin
            cmd.op     = CMD_ERASE;
            cmd.wr_idx = pos_ext[IDX_W-1:0];
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = pos_ext[IDX_W-1:0];
            count_d    = cnt_dec;
          end
        end
        default: stat_d = ST_OK;
      endcase
    end
  end

  // Chain of cells, each fed by its neighbours
  for (genvar i = 0; i < LIST_CAP; i++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = entry[i-1];
    end
    if (i == LIST_CAP - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = entry[i+1];
    end
    ali_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[i]),
      .rd_o    (rd_val[i])
    );
  end

  ali_gather u_gather (
    .clk_i   (clk_i),
    .load_i  (in_acc),
    .cells_i (rd_val),
    .data_o  (removed)
  );

  // Advance the item through gather and output
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_GATHER;
      S_GATHER: state_d = S_OUT;
      S_OUT: begin
        if (in_acc) begin
          state_d = S_GATHER;
        end else if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Hold length and status while the removed word is gathered
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q  <= LEN_W'(count_d);
      stat_q <= stat_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_GATHER) begin
      out_q.removed_value <= removed;
      out_q.length        <= len_q;
      out_q.status        <= stat_q;
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_o       = out_q;

endmodule

`default_nettype wire

[rtl/core/ali_cell.sv]
// One slot of the list: holds a word and trades it with its neighbours
`default_nettype none

module ali_cell import ali_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire cell_cmd_t         cmd_i,
  input  wire logic [DATA_W-1:0] lower_i,
  input  wire logic [DATA_W-1:0] upper_i,
  output logic      [DATA_W-1:0] entry_o,
  output logic      [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] entry_d, entry_q;

  // Load at the target slot, shift up above it on write, shift down on erase
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CMD_WRITE: begin
        if (idx_i == cmd_i.wr_idx) begin
          entry_d = cmd_i.value;
        end else if (idx_i > cmd_i.wr_idx) begin
          entry_d = lower_i;
        end
      end
      CMD_ERASE: begin
        if (idx_i >= cmd_i.wr_idx) begin
          entry_d = upper_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Offer the stored word to the gather tree only when addressed
  assign rd_o = (cmd_i.rd_en && (idx_i == cmd_i.rd_idx)) ? entry_q : '0;

endmodule

`default_nettype wire

[rtl/core/ali_gather.sv]
// Two-level OR tree collecting the word read out of the cell chain
`default_nettype none

module ali_gather import ali_pkg::*; (
  input  wire logic                             clk_i,
  input  wire logic                             load_i,
  input  wire logic [LIST_CAP-1:0][DATA_W-1:0]  cells_i,
  output logic      [DATA_W-1:0]                data_o
);

  logic [GRP_NUM-1:0][DATA_W-1:0] grp_d, grp_q;

  // Merge each group of cells
  always_comb begin
    int unsigned k;
    for (int unsigned g = 0; g < GRP_NUM; g++) begin
      grp_d[g] = '0;
      for (int unsigned j = 0; j < GRP_SIZE; j++) begin
        k = g * GRP_SIZE + j;
        if (k < LIST_CAP) begin
          grp_d[g] = grp_d[g] | cells_i[k[IDX_W-1:0]];
        end
      end
    end
  end

  // Hold group results until the next load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  // Merge the groups
  always_comb begin
    data_o = '0;
    for (int unsigned g = 0; g < GRP_NUM; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule

`default_nettype wire

[rtl/core/ali_checker.sv]
// Port-level assertions for the array list, bound to the top level
`default_nettype none

`include "array_list_insert_erase_defines.svh"

module ali_checker import ali_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire ali_out_t out_o
);

  logic in_xfer;
  logic res_full, res_empty, res_rm;
  logic len_cap, empty_ok;

  // Qualify each result report by its valid
  assign in_xfer   = in_valid_i && in_ready_o;
  assign res_full  = out_valid_o && (out_o.status == ST_FULL);
  assign res_empty = out_valid_o && (out_o.status == ST_EMPTY);
  assign res_rm    = out_valid_o && (out_o.removed_value != '0);
  assign len_cap   = (out_o.length == LEN_W'(LIST_CAP));
  assign empty_ok  = (out_o.length == '0) && (out_o.removed_value == '0);

  // A full report means the list holds its capacity
  `ALI_ASSERT_IMP(a_full_len, res_full, len_cap)

  // An empty report means nothing stored and nothing removed
  `ALI_ASSERT_IMP(a_empty_len, res_empty, empty_ok)

  // A removed word only comes with a successful operation
  `ALI_ASSERT_IMP(a_rm_ok, res_rm, out_o.status == ST_OK)

  // The result never shows in the cycle after a transfer in
  `ALI_ASSERT_NXT(a_latency, in_xfer, !out_valid_o)

endmodule

bind array_list_insert_erase ali_checker u_ali_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Testbench for the array list: shadow list scoreboard, random handshake pressure
`timescale 1ns / 1ps

module tb;
  import ali_pkg::*;

  localparam int unsigned DIRECTED_ITEMS = 24;
  localparam int unsigned RANDOM_ITEMS   = 450;
  localparam int unsigned QUIET_ITEMS    = 60;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  // Shadow copy of the list; predicts each result and checks it in order
  class list_tracker;
    logic [DATA_W-1:0] words[LIST_CAP];
    int unsigned       fill;
    int unsigned       mismatches;
    ali_out_t          expected_results[$];

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted operation to the shadow list and queue its result
    function void record_op(ali_in_t item);
      ali_out_t    res;
      int unsigned pos;
      res.removed_value = '0;
      res.status        = ST_OK;
      pos               = item.position;
      case (func_e'(item.func))
        FN_PUSH: begin
          if (fill >= LIST_CAP) begin
            res.status = ST_FULL;
          end else begin
            words[fill] = item.value;
            fill++;
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            fill--;
            res.removed_value = words[fill];
          end
        end
        FN_INSERT: begin
          if (fill >= LIST_CAP) begin
            res.status = ST_FULL;
          end else if (pos > fill) begin
            res.status = ST_RANGE;
          end else begin
            for (int i = fill; i > pos; i--) words[i] = words[i-1];
            words[pos] = item.value;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= fill) begin
            res.status = ST_RANGE;
          end else begin
            res.removed_value = words[pos];
            for (int i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
      endcase
      res.length = LEN_W'(fill);
      expected_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(ali_out_t got);
      ali_out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.removed_value !== want.removed_value) begin
        $display("%0t: removed_value expected %h actual %h", $time,
                 want.removed_value, got.removed_value);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  ali_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  ali_out_t out_item;

  list_tracker tracker;
  bit          quiet;
  bit          filling;
  int unsigned cycles;
  int unsigned sent;
  int unsigned stall_left;

  array_list_insert_erase u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Observe transfers on both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) tracker.record_op(in_item);
      if (out_valid && out_ready) tracker.check_result(out_item);
    end
  end

  // Guard against a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: stall in random bursts, never during the quiet tail
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready  = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_W-2){1'b0}}, 1'b1};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic ali_in_t make_item(func_e fn, logic [DATA_W-1:0] val,
                                        logic [POS_W-1:0] pos);
    ali_in_t item;
    item.func     = fn;
    item.value    = val;
    item.position = pos;
    return item;
  endfunction

  // Pick the next random operation; the list swings between full and empty
  function automatic ali_in_t next_item();
    ali_in_t     item;
    int unsigned r;
    int unsigned top;
    bit          grow;
    item = make_item(func_e'($urandom_range(0, 3)), rand_word(), POS_W'($urandom));
    if (tracker.fill == LIST_CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
    if (tracker.fill == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 10) return item;
    grow = filling ? (r < 75) : (r >= 75);
    if (grow) begin
      top = (tracker.fill > LIST_CAP - 1) ? LIST_CAP - 1 : tracker.fill;
      if ($urandom_range(0, 1) == 0) begin
        item.func = FN_PUSH;
      end else begin
        item.func     = FN_INSERT;
        item.position = POS_W'($urandom_range(0, top));
      end
    end else begin
      if ($urandom_range(0, 1) == 0 || tracker.fill == 0) begin
        item.func = FN_POP;
      end else begin
        item.func     = FN_ERASE;
        item.position = POS_W'($urandom_range(0, tracker.fill - 1));
      end
    end
    return item;
  endfunction

  // Hold the item on the input channel until it is transferred
  task automatic send_item(ali_in_t item);
    @(negedge clk_i);
    in_valid = 1'b1;
    in_item  = item;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    if (sent >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 8));
  endtask

  // Drop valid for a number of cycles
  task automatic idle_input(int unsigned n);
    @(negedge clk_i);
    in_valid = 1'b0;
    in_item  = {FUNC_W'($urandom), rand_word(), POS_W'($urandom)};
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    tracker  = new();
    quiet    = 1'b0;
    filling  = 1'b1;
    cycles   = 0;
    sent     = 0;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: errors on an empty list, edge positions, extreme words
    send_item(make_item(FN_POP, '1, '0));
    send_item(make_item(FN_ERASE, '0, 6'd0));
    send_item(make_item(FN_ERASE, '0, 6'd63));
    send_item(make_item(FN_INSERT, '1, 6'd1));
    send_item(make_item(FN_INSERT, '1, 6'd63));
    send_item(make_item(FN_INSERT, '1, 6'd0));
    send_item(make_item(FN_PUSH, '0, 6'd0));
    send_item(make_item(FN_PUSH, {32{2'b01}}, 6'd0));
    send_item(make_item(FN_INSERT, {32{2'b10}}, 6'd3));
    send_item(make_item(FN_INSERT, {1'b1, 62'd0, 1'b1}, 6'd0));
    send_item(make_item(FN_INSERT, rand_word(), 6'd2));
    send_item(make_item(FN_ERASE, '0, 6'd6));
    send_item(make_item(FN_ERASE, '0, 6'd63));
    send_item(make_item(FN_INSERT, rand_word(), 6'd7));
    send_item(make_item(FN_ERASE, '1, 6'd2));
    send_item(make_item(FN_ERASE, '0, 6'd0));
    send_item(make_item(FN_ERASE, '0, 6'd3));
    send_item(make_item(FN_POP, '0, 6'd0));
    send_item(make_item(FN_PUSH, rand_word(), 6'd63));
    send_item(make_item(FN_POP, '1, 6'd63));
    send_item(make_item(FN_POP, '0, 6'd0));
    send_item(make_item(FN_POP, '0, 6'd0));
    send_item(make_item(FN_POP, '0, 6'd0));
    send_item(make_item(FN_ERASE, '1, 6'd0));

    // Random: runs that fill the list, hit full, drain it and hit empty
    repeat (RANDOM_ITEMS) send_item(next_item());

    @(negedge clk_i);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ali_pkg.sv
rtl/core/ali_cell.sv
rtl/core/ali_gather.sv
rtl/core/array_list_insert_erase.sv
rtl/core/ali_checker.sv
tb/tb.sv
